@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers used by the allocator unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/fcba_pkg.sv @@
package fcba_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = 4;
  localparam int NBYTES_W   = 16;
  localparam int BLK_OUT_W  = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCKS = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_BAD_SLOT  = 2'd3
  } fcba_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_LINK,
    S_LINK_END,
    S_FCHK,
    S_WALK_RD,
    S_WALK_WR,
    S_FREE_END
  } fcba_state_t;

  typedef struct packed {
    logic         load;
    logic         scan_step;
    logic         slot_init;
    logic         slot_step;
    logic         link_init;
    logic         link_step;
    logic         link_end;
    logic         walk_init;
    logic         walk_free;
    logic         free_commit;
    logic         finish;
    fcba_status_t fin_status;
  } fcba_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic scan_ok;
    logic slot_hit;
    logic slot_last;
    logic link_last;
    logic free_ok;
    logic walk_stop;
    logic walk_end;
  } fcba_stat_t;

endpackage

@@ rtl/fcba_ctrl.sv @@
module fcba_ctrl import fcba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_cmd,
  input  fcba_stat_t stat_i,
  output fcba_cmd_t  cmd_o,
  output logic       busy
);

  fcba_state_t state_r;
  fcba_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = in_cmd ? S_FCHK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_nxt = stat_i.scan_ok ? S_SLOT : S_IDLE;
        end
      end
      S_SLOT: begin
        if (stat_i.slot_hit) begin
          state_nxt = S_LINK;
        end else if (stat_i.slot_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        if (stat_i.link_last) begin
          state_nxt = S_LINK_END;
        end
      end
      S_LINK_END: state_nxt = S_IDLE;
      S_FCHK: begin
        state_nxt = stat_i.free_ok ? S_WALK_RD : S_IDLE;
      end
      S_WALK_RD: begin
        state_nxt = stat_i.walk_stop ? S_FREE_END : S_WALK_WR;
      end
      S_WALK_WR: begin
        state_nxt = stat_i.walk_end ? S_FREE_END : S_WALK_RD;
      end
      S_FREE_END: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.fin_status = ST_OK;
    unique case (state_r)
      S_IDLE: cmd_o.load = start;
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.scan_ok) begin
            cmd_o.slot_init = 1'b1;
          end else begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_NO_BLOCKS;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SLOT: begin
        if (stat_i.slot_hit) begin
          cmd_o.link_init = 1'b1;
        end else if (stat_i.slot_last) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_NO_SLOT;
        end else begin
          cmd_o.slot_step = 1'b1;
        end
      end
      S_LINK: cmd_o.link_step = 1'b1;
      S_LINK_END: begin
        cmd_o.link_end = 1'b1;
        cmd_o.finish   = 1'b1;
      end
      S_FCHK: begin
        if (stat_i.free_ok) begin
          cmd_o.walk_init = 1'b1;
        end else begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_BAD_SLOT;
        end
      end
      S_WALK_RD: cmd_o.load = 1'b0;
      S_WALK_WR: cmd_o.walk_free = 1'b1;
      S_FREE_END: begin
        cmd_o.free_commit = 1'b1;
        cmd_o.finish      = 1'b1;
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/fcba_datapath.sv @@
module fcba_datapath import fcba_pkg::*; #(
  parameter int BLOCK_COUNT = 16,
  parameter int BLOCK_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_cmd,
  input  logic [NBYTES_W-1:0]  in_nbytes,
  input  logic [SLOT_W-1:0]    in_slot,
  input  fcba_cmd_t            cmd_i,
  output fcba_stat_t           stat_o,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [BLK_OUT_W-1:0] out_start_block,
  output logic [SLOT_W-1:0]    out_file_slot
);

  localparam int BW = $clog2(BLOCK_COUNT);
  localparam int IW = BW + 1;
  localparam int AW = $clog2(BLOCK_COUNT * BLOCK_BYTES + 1);
  localparam int CW = (AW > NBYTES_W) ? AW : NBYTES_W;
  localparam logic [IW-1:0] N_IDX   = IW'(BLOCK_COUNT);
  localparam logic [CW-1:0] BB_STEP = CW'(BLOCK_BYTES);

  // Free map: one bit per block, entry 0 reserved and never free.
  logic [BLOCK_COUNT-1:0] free_r;
  // Link memory: {end mark, next block}.
  logic [BW:0]            link_mem [BLOCK_COUNT];
  logic [BW:0]            rd_data_r;
  logic [BW-1:0]          fs_r [SLOT_COUNT];

  logic [IW-1:0]          idx_r;
  logic [IW-1:0]          steps_r;
  logic [BW-1:0]          prev_r;
  logic [BW-1:0]          start_r;
  logic [BW-1:0]          last_r;
  logic                   have_r;
  logic [CW-1:0]          avail_r;
  logic [CW-1:0]          avail_nxt;
  logic [SLOT_W-1:0]      slot_idx_r;
  logic [SLOT_W-1:0]      slot_r;
  logic                   is_free_r;
  logic [NBYTES_W-1:0]    nbytes_r;

  logic                   out_valid_r;
  fcba_status_t           out_status_r;
  logic [BLK_OUT_W-1:0]   out_blk_r;
  logic [SLOT_W-1:0]      out_slot_r;

  logic [BW-1:0]          idx_lo;
  logic                   in_range;
  logic                   free_bit;
  logic                   sat_hit;
  logic                   take;
  logic [SLOT_W-1:0]      fs_addr;
  logic [BW-1:0]          fs_rd;
  logic                   mem_we;
  logic [BW:0]            mem_wdata;

  assign idx_lo   = idx_r[BW-1:0];
  assign in_range = (idx_r < N_IDX);
  assign free_bit = in_range && free_r[idx_lo];
  assign sat_hit  = have_r && (avail_r >= CW'(nbytes_r));
  assign take     = free_bit && !sat_hit;
  assign avail_nxt = have_r ? (avail_r + BB_STEP) : BB_STEP;

  assign fs_addr = is_free_r ? slot_r : slot_idx_r;
  assign fs_rd   = fs_r[fs_addr];

  assign mem_we    = (cmd_i.link_step && free_bit && (idx_lo != start_r)) || cmd_i.link_end;
  assign mem_wdata = cmd_i.link_end ? {1'b1, {BW{1'b0}}} : {1'b0, idx_lo};

  always_comb begin
    stat_o.scan_done = (idx_r == N_IDX) || sat_hit;
    stat_o.scan_ok   = sat_hit;
    stat_o.slot_hit  = (fs_rd == '0);
    stat_o.slot_last = (slot_idx_r == SLOT_W'(SLOT_COUNT - 1));
    stat_o.link_last = (idx_lo == last_r);
    stat_o.free_ok   = (slot_r != '0) && (fs_rd != '0);
    stat_o.walk_stop = (idx_r == '0) || !in_range || free_bit || (steps_r == N_IDX);
    stat_o.walk_end  = rd_data_r[BW];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[prev_r] <= mem_wdata;
    end
    rd_data_r <= link_mem[idx_lo];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= {{(BLOCK_COUNT - 1){1'b1}}, 1'b0};
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        fs_r[i] <= '0;
      end
    end else begin
      out_valid_r <= cmd_i.finish;
      if (cmd_i.link_step && free_bit) begin
        free_r[idx_lo] <= 1'b0;
      end
      if (cmd_i.walk_free) begin
        free_r[idx_lo] <= 1'b1;
      end
      if (cmd_i.link_end) begin
        fs_r[slot_idx_r] <= start_r;
      end
      if (cmd_i.free_commit) begin
        fs_r[slot_r] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      is_free_r <= in_cmd;
      nbytes_r  <= in_nbytes;
      slot_r    <= in_slot;
      idx_r     <= IW'(1);
      have_r    <= 1'b0;
      avail_r   <= '0;
    end
    if (cmd_i.scan_step) begin
      idx_r <= idx_r + IW'(1);
      if (take) begin
        if (!have_r) begin
          start_r <= idx_lo;
        end
        have_r  <= 1'b1;
        avail_r <= avail_nxt;
        last_r  <= idx_lo;
      end
    end
    if (cmd_i.slot_init) begin
      slot_idx_r <= SLOT_W'(1);
    end
    if (cmd_i.slot_step) begin
      slot_idx_r <= slot_idx_r + SLOT_W'(1);
    end
    if (cmd_i.link_init) begin
      idx_r  <= {1'b0, start_r};
      prev_r <= start_r;
    end
    if (cmd_i.link_step) begin
      idx_r <= idx_r + IW'(1);
      if (free_bit && (idx_lo != start_r)) begin
        prev_r <= idx_lo;
      end
    end
    if (cmd_i.walk_init) begin
      idx_r   <= {1'b0, fs_rd};
      steps_r <= '0;
    end
    if (cmd_i.walk_free) begin
      steps_r <= steps_r + IW'(1);
      if (!rd_data_r[BW]) begin
        idx_r <= {1'b0, rd_data_r[BW-1:0]};
      end
    end
    if (cmd_i.finish) begin
      out_status_r <= cmd_i.fin_status;
      if ((cmd_i.fin_status == ST_OK) && !is_free_r) begin
        out_blk_r  <= BLK_OUT_W'(start_r);
        out_slot_r <= slot_idx_r;
      end else begin
        out_blk_r  <= '0;
        out_slot_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_blk_r;
  assign out_file_slot   = out_slot_r;

endmodule

@@ rtl/fat_chain_block_allocator_unit.sv @@
// Chain block allocator with a file start table.
// Input: pulse start with in_cmd, in_nbytes, in_slot while busy is low; the
// transaction is taken at that edge and busy rises on the next cycle.
// in_cmd = 0 allocates a chain covering in_nbytes; in_cmd = 1 frees in_slot.
// Result: out_valid strobes for one cycle with out_status, out_start_block
// and out_file_slot. The receiver cannot stall; the result is gone after
// that cycle. The next transaction may be issued in the same cycle.
// Sequence: allocate runs the block scan, the slot search and the linking
// in turn. Free walks the chain, reading and then releasing each block; an
// invalid slot is rejected by the slot check before any walk. The link
// memory is read and written at one entry per cycle, and one block index is
// shared by the scan, the link and the walk.
// Reset: all blocks but block 0 are free and all file slots empty; no
// clearing pass is needed since links are written before they are read.
`include "assert_macros.svh"

module fat_chain_block_allocator_unit import fcba_pkg::*; #(
  parameter int BLOCK_COUNT = 16,
  parameter int BLOCK_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [NBYTES_W-1:0]  in_nbytes,
  input  logic [SLOT_W-1:0]    in_slot,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [BLK_OUT_W-1:0] out_start_block,
  output logic [SLOT_W-1:0]    out_file_slot
);

  fcba_cmd_t  cmd;
  fcba_stat_t stat;

  // Sequence each transaction: scan, slot search, link, or walk and release.
  fcba_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Hold the free map, link memory, slot table and result register.
  fcba_datapath #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_nbytes       (in_nbytes),
    .in_slot         (in_slot),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_block (out_start_block),
    .out_file_slot   (out_file_slot)
  );

  // An accepted transaction keeps the block busy on the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // A result only follows a cycle of work.
  `ASSERT_IMPLY(a_result_after_busy, clk, rst_n, out_valid, $past(busy))
  // Failures report no block and no slot.
  `ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK),
                (out_start_block == '0) && (out_file_slot == '0))

endmodule
